/* hdl/fwr_pkg.sv */
package fwr_pkg;

  // Field widths of the command and result channels
  localparam int CMD_W  = 3;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 64;
  localparam int SIZE_W = 11;

  // Default table depth and reset value of the size register
  localparam int                TABLE_SIZE_DEF = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RST       = 11'd1024;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_QUERY = 3'd2,
    CMD_BEGIN = 3'd3,
    CMD_END   = 3'd4
  } cmd_t;

endpackage

/* hdl/fwr_in_if.sv */
interface fwr_in_if
  import fwr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

/* hdl/fwr_out_if.sv */
interface fwr_out_if
  import fwr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] prefix_sum;
  logic                    error;

  modport source (output valid, prefix_sum, error, input ready);
  modport sink   (input valid, prefix_sum, error, output ready);
endinterface

/* hdl/fenwick_tree_with_rollback.sv */
// Operation: add/set write the point value and walk the change up the tree levels; query walks
//   down the one bits of the clamped position; begin record clears all touch marks; end record
//   sets each touched position back to zero; errors and unknown commands go straight to a result.
// Throughput: one command at a time; the single 64-bit adder and the one read port per store
//   set the pace of one tree level per cycle. A new command can be taken once the result is presented.
// Reset: synchronous, active low. Afterwards a clearing pass zeroes every entry of all three
//   stores with in_ready low; configuration writes are taken during it.
module fenwick_tree_with_rollback
  import fwr_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  fwr_in_if.sink            in_ch,
  fwr_out_if.source         out_ch
);

  localparam int              AW   = $clog2(TABLE_SIZE);
  localparam int              PW   = AW + 1;
  localparam int              CW   = (PW > SIZE_W) ? PW : SIZE_W;
  localparam logic [AW-1:0]   LAST = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0]   TS_C = CW'(TABLE_SIZE);
  localparam logic [PW-1:0]   TS_P = PW'(TABLE_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_TREE,
    S_QRY,
    S_TCLR,
    S_END_RD,
    S_END_CHK,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt, fin_state;
  logic [AW-1:0]      sw_r, sw_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [VAL_W-1:0]   delta_r, delta_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic               add_mode_r, add_mode_nxt;
  logic               end_mode_r, end_mode_nxt;
  logic [SIZE_W-1:0]  asz_r, asz_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_sum_r, out_sum_nxt;
  logic               out_err_r, out_err_nxt;

  // Store ports
  logic               pt_we, ps_we, tm_we;
  logic [AW-1:0]      pt_waddr, ps_waddr, tm_waddr;
  logic [AW-1:0]      pt_raddr, ps_raddr, tm_raddr;
  logic [VAL_W-1:0]   pt_wdata, ps_wdata, pt_rdata, ps_rdata;
  logic               tm_wdata, tm_rdata;

  // Shared adder
  logic [VAL_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub;

  logic               in_fire, sw_last;
  cmd_t               in_cmd;
  logic [CW-1:0]      size_c, pos_c, q_c;
  logic [PW-1:0]      q_p, lsb_p, p_up, p_dn;
  logic               upd_bad;
  logic [VAL_W-1:0]   delta_c;

  fwr_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_point (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  fwr_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_psum (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );

  fwr_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_touch (
    .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
    .raddr(tm_raddr), .rdata(tm_rdata)
  );

  // Handshake
  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign in_cmd            = cmd_t'(in_ch.cmd);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.prefix_sum = out_sum_r;
  assign out_ch.error      = out_err_r;

  // Effective size, position check and query clamp
  always_comb begin
    if (asz_r == '0) begin
      size_c = CW'(1);
    end else if (CW'(asz_r) > TS_C) begin
      size_c = TS_C;
    end else begin
      size_c = CW'(asz_r);
    end
    pos_c   = CW'(in_ch.position);
    upd_bad = (pos_c == '0) || (pos_c >= size_c);
    q_c     = (pos_c > size_c - CW'(1)) ? size_c - CW'(1) : pos_c;
    q_p     = q_c[PW-1:0];
  end

  // Tree index steps
  assign lsb_p   = p_r & (~p_r + PW'(1));
  assign p_up    = p_r + lsb_p;
  assign p_dn    = p_r - lsb_p;
  assign sw_last = (sw_r == LAST);

  // Where an update goes when its tree walk ends
  always_comb begin
    fin_state = (end_mode_r && !sw_last) ? S_END_RD : S_DONE;
  end

  // Adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_UPD: begin
        if (add_mode_r) begin
          alu_a = pt_rdata;
          alu_b = val_r;
        end else begin
          alu_a   = val_r;
          alu_b   = pt_rdata;
          alu_sub = 1'b1;
        end
      end
      S_TREE: begin
        alu_a = ps_rdata;
        alu_b = delta_r;
      end
      S_QRY: begin
        alu_a = acc_r;
        alu_b = ps_rdata;
      end
      default: begin
      end
    endcase
  end

  assign alu_y   = alu_a + (alu_b ^ {VAL_W{alu_sub}}) + VAL_W'(alu_sub);
  assign delta_c = add_mode_r ? val_r : alu_y;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    val_nxt       = val_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    add_mode_nxt  = add_mode_r;
    end_mode_nxt  = end_mode_r;
    asz_nxt       = cfg_we ? cfg_wdata : asz_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;

    pt_we    = 1'b0;
    pt_waddr = pos_r;
    pt_wdata = val_r;
    pt_raddr = sw_r;
    ps_we    = 1'b0;
    ps_waddr = p_r[AW-1:0];
    ps_wdata = alu_y;
    ps_raddr = p_r[AW-1:0];
    tm_we    = 1'b0;
    tm_waddr = pos_r;
    tm_wdata = 1'b0;
    tm_raddr = sw_r;

    case (state_r)
      // Zero all three stores after reset
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = sw_r;
        pt_wdata = '0;
        ps_we    = 1'b1;
        ps_waddr = sw_r;
        ps_wdata = '0;
        tm_we    = 1'b1;
        tm_waddr = sw_r;
        if (sw_last) begin
          state_nxt = S_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end

      // Take a command; prefetch the point value and the first query node
      S_IDLE: begin
        pt_raddr = AW'(in_ch.position);
        ps_raddr = q_p[AW-1:0];
        if (in_fire) begin
          acc_nxt      = '0;
          err_nxt      = 1'b0;
          pos_nxt      = AW'(in_ch.position);
          val_nxt      = in_ch.value;
          add_mode_nxt = (in_cmd == CMD_ADD);
          end_mode_nxt = (in_cmd == CMD_END);
          case (in_cmd)
            CMD_ADD, CMD_SET: begin
              if (upd_bad) begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_UPD;
              end
            end
            CMD_QUERY: begin
              p_nxt     = q_p;
              state_nxt = (q_p == '0) ? S_DONE : S_QRY;
            end
            CMD_BEGIN: begin
              sw_nxt    = '0;
              state_nxt = S_TCLR;
            end
            CMD_END: begin
              sw_nxt    = AW'(1);
              state_nxt = S_END_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Point value is in; write new value, set the touch mark (clear it in end record), start the walk
      S_UPD: begin
        pt_we     = 1'b1;
        pt_waddr  = pos_r;
        pt_wdata  = add_mode_r ? alu_y : val_r;
        tm_we     = 1'b1;
        tm_waddr  = pos_r;
        tm_wdata  = !end_mode_r;
        ps_raddr  = pos_r;
        delta_nxt = delta_c;
        p_nxt     = PW'(pos_r);
        if (delta_c == '0) begin
          state_nxt = fin_state;
          sw_nxt    = sw_r + AW'(1);
        end else begin
          state_nxt = S_TREE;
        end
      end

      // One tree level per cycle: write this node, read the parent
      S_TREE: begin
        ps_we    = 1'b1;
        ps_waddr = p_r[AW-1:0];
        ps_wdata = alu_y;
        ps_raddr = p_up[AW-1:0];
        p_nxt    = p_up;
        if (p_up >= TS_P) begin
          state_nxt = fin_state;
          sw_nxt    = sw_r + AW'(1);
        end
      end

      // Prefix walk: accumulate and read the next node down
      S_QRY: begin
        acc_nxt  = alu_y;
        p_nxt    = p_dn;
        ps_raddr = p_dn[AW-1:0];
        if (p_dn == '0) begin
          state_nxt = S_DONE;
        end
      end

      // Begin record: forget all touch marks
      S_TCLR: begin
        tm_we    = 1'b1;
        tm_waddr = sw_r;
        if (sw_last) begin
          state_nxt = S_DONE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end

      // End record sweep: read mark and point value together
      S_END_RD: begin
        state_nxt = S_END_CHK;
      end

      S_END_CHK: begin
        if (tm_rdata) begin
          pos_nxt      = sw_r;
          val_nxt      = '0;
          add_mode_nxt = 1'b0;
          state_nxt    = S_UPD;
        end else if (sw_last) begin
          state_nxt = S_DONE;
        end else begin
          sw_nxt    = sw_r + AW'(1);
          state_nxt = S_END_RD;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    p_r        <= p_nxt;
    val_r      <= val_nxt;
    delta_r    <= delta_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    add_mode_r <= add_mode_nxt;
    end_mode_r <= end_mode_nxt;
    out_sum_r  <= out_sum_nxt;
    out_err_r  <= out_err_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sw_r        <= '0;
      asz_r       <= SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      asz_r       <= asz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/fwr_ram.sv */
module fwr_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/fwr_checker.sv */
module fwr_checker
  import fwr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_prefix_sum,
  input logic             out_error
);

  // Reset leaves no result pending and runs the clearing pass first
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready seen right after reset");

  // One command at a time: busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous still in work");

  // A new result is only produced while no command is being taken
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced while idle");

  // An error result never carries a sum
  a_error_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_prefix_sum == '0)
    else $error("error result with nonzero sum");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_prefix_sum) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind fenwick_tree_with_rollback fwr_checker u_fwr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_prefix_sum (out_ch.prefix_sum),
  .out_error      (out_ch.error)
);
